// File: hw/rtl/cbtod_pkg.sv
// constants and digit helpers for the calibrated bcd time-of-day clock
// no dependencies; used by calibrated_bcd_time_of_day_top

package cbtod_pkg;

	// slow-clock cycles times calibration give microseconds; one second is 2^6 * 15625 us
	localparam int unsigned US_SHIFT    = 6;
	localparam int unsigned PROD_W      = 52;
	localparam int unsigned DIVIDEND_W  = PROD_W - US_SHIFT;

	// floor(d / 15625) = (d * SEC_RECIP) >> SEC_SHIFT for d < 2^46
	localparam logic [46:0] SEC_RECIP    = 47'd73786976294839;
	localparam logic [22:0] SEC_RECIP_HI = SEC_RECIP[46:24];
	localparam logic [23:0] SEC_RECIP_LO = SEC_RECIP[23:0];
	localparam int unsigned SEC_SHIFT    = 60;
	localparam int unsigned SECS_W       = 33;

	// time of day as seconds since midnight
	localparam logic [16:0] DAY_SECONDS = 17'd86400;

	// floor(s / 86400) = ((s >> DAY_PRE) * DAY_RECIP) >> DAY_SHIFT for s < 2^33
	localparam logic [26:0] DAY_RECIP   = 27'd101806633;
	localparam int unsigned DAY_PRE     = 7;
	localparam int unsigned DAY_SHIFT   = 36;

	// floor(t / 3600) = (t * HOUR_RECIP) >> HOUR_SHIFT for t < 2^17
	localparam logic [17:0] HOUR_RECIP  = 18'd149131;
	localparam int unsigned HOUR_SHIFT  = 29;
	localparam logic [11:0] HOUR_SECS   = 12'd3600;

	// floor(r / 60) = (r * MIN_RECIP) >> MIN_SHIFT for r < 2^12
	localparam logic [12:0] MIN_RECIP   = 13'd4370;
	localparam int unsigned MIN_SHIFT   = 18;
	localparam logic [5:0]  MIN_SECS    = 6'd60;

	// tens digit of a value below 60
	function automatic logic [2:0] tens_of(input logic [5:0] v);
		logic [2:0] t;
		t = 3'd0;
		if (v >= 6'd10) t = 3'd1;
		if (v >= 6'd20) t = 3'd2;
		if (v >= 6'd30) t = 3'd3;
		if (v >= 6'd40) t = 3'd4;
		if (v >= 6'd50) t = 3'd5;
		return t;
	endfunction

	// ones digit of a value below 60
	function automatic logic [3:0] ones_of(input logic [5:0] v);
		logic [5:0] tens_val;
		tens_val = 6'(tens_of(v)) * 6'd10;
		return 4'(v - tens_val);
	endfunction

endpackage

// File: hw/rtl/calibrated_bcd_time_of_day_top.sv
// calibrated bcd time-of-day clock, 24-hour, top level
// depends on cbtod_pkg (constants, digit split functions)

// Takes one word per clock and returns one word per clock. A word carries a
// command and a sample of a free-running 32-bit slow-clock counter: restart
// zeroes the clock, update advances it by floor((sample - last sample) *
// calibration / 1e6) seconds. Every result word is the six bcd digits
// hh:mm:ss after the word. The block is a 13-stage pipeline: sample
// difference and product take one stage each, the divide by one million is
// a reciprocal multiply over three stages, reducing the seconds modulo one
// day takes two, one stage adds them to the time of day, and five stages
// turn seconds since midnight into digits. A result word is registered in
// each stage in turn and leaves from the s13 output register. The add of the
// time of day is the only loop, so throughput is one word per cycle; the
// input stalls only once all 13 stages are full and the output is stalled.
// The calibration register may only be written while no word is in flight.

module calibrated_bcd_time_of_day_top (
	input  logic        clk,
	input  logic        arst_n,
	// calibration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [19:0] cfg_data,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [31:0] cycle_sample,
	// result words
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  hour_tens,
	output logic [3:0]  hour_ones,
	output logic [2:0]  minute_tens,
	output logic [3:0]  minute_ones,
	output logic [2:0]  second_tens,
	output logic [3:0]  second_ones
);

	localparam int unsigned ST_AC = 7;
	localparam int unsigned NSTG  = ST_AC + 6;
	localparam int unsigned SW    = cbtod_pkg::SECS_W;

	// pipeline flow control
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] rdy;
	logic [NSTG-1:0] ld;

	assign rdy[NSTG-1] = !vld_q[NSTG-1] || !out_stall;
	assign ld[0]       = in_valid && rdy[0];

	for (genvar k = 0; k < NSTG - 1; k++) begin : g_flow
		assign rdy[k]   = !vld_q[k] || rdy[k+1];
		assign ld[k+1]  = vld_q[k] && rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < NSTG; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = vld_q[NSTG-1];

	// calibration register
	logic [19:0] cal_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			cal_q <= cfg_data;
		end
	end

	// s1: elapsed cycles since the previous sample
	logic [31:0] last_sample_q;
	logic [31:0] diff_s1;
	logic        cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q <= '0;
		end else if (ld[0]) begin
			last_sample_q <= cycle_sample;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			diff_s1 <= cycle_sample - last_sample_q;
			cmd_s1  <= cmd;
		end
	end

	// s2: elapsed microseconds
	logic [cbtod_pkg::PROD_W-1:0] prod;
	logic [cbtod_pkg::PROD_W-1:0] prod_s2;
	logic                         cmd_s2;

	assign prod = diff_s1 * cal_q;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			prod_s2 <= prod;
			cmd_s2  <= cmd_s1;
		end
	end

	// s3: product shifted down by 6 times the reciprocal of 15625,
	// as four partial products
	logic [cbtod_pkg::DIVIDEND_W-1:0] dvd;
	logic [22:0] dvd_hi;
	logic [22:0] dvd_lo;
	logic [45:0] pp_hh;
	logic [46:0] pp_hl;
	logic [45:0] pp_lh;
	logic [46:0] pp_ll;
	logic [45:0] pp_hh_s3;
	logic [46:0] pp_hl_s3;
	logic [45:0] pp_lh_s3;
	logic [46:0] pp_ll_s3;
	logic        cmd_s3;

	assign dvd    = prod_s2[cbtod_pkg::PROD_W-1:cbtod_pkg::US_SHIFT];
	assign dvd_hi = dvd[45:23];
	assign dvd_lo = dvd[22:0];
	assign pp_hh  = dvd_hi * cbtod_pkg::SEC_RECIP_HI;
	assign pp_hl  = dvd_hi * cbtod_pkg::SEC_RECIP_LO;
	assign pp_lh  = dvd_lo * cbtod_pkg::SEC_RECIP_HI;
	assign pp_ll  = dvd_lo * cbtod_pkg::SEC_RECIP_LO;

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			pp_hh_s3 <= pp_hh;
			pp_hl_s3 <= pp_hl;
			pp_lh_s3 <= pp_lh;
			pp_ll_s3 <= pp_ll;
			cmd_s3   <= cmd_s2;
		end
	end

	// s4: merge the two cross terms (pp_hl sits 23 bits up, pp_lh one bit higher)
	logic [47:0] pp_mid;
	logic [45:0] pp_hh_s4;
	logic [47:0] pp_mid_s4;
	logic [46:0] pp_ll_s4;
	logic        cmd_s4;

	assign pp_mid = {1'b0, pp_hl_s3} + {1'b0, pp_lh_s3, 1'b0};

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			pp_hh_s4  <= pp_hh_s3;
			pp_mid_s4 <= pp_mid;
			pp_ll_s4  <= pp_ll_s3;
			cmd_s4    <= cmd_s3;
		end
	end

	// s5: whole elapsed seconds from the top of the full product
	logic [92:0]   recip_full;
	logic [SW-1:0] secs_s5;
	logic          cmd_s5;

	assign recip_full = {pp_hh_s4, 47'd0} + {22'd0, pp_mid_s4, 23'd0} + {46'd0, pp_ll_s4};

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			secs_s5 <= recip_full[cbtod_pkg::SEC_SHIFT +: SW];
			cmd_s5  <= cmd_s4;
		end
	end

	// s6: whole days in the elapsed seconds
	logic [52:0]   day_prod;
	logic [16:0]   days_s6;
	logic [SW-1:0] secs_s6;
	logic          cmd_s6;

	assign day_prod = secs_s5[SW-1:cbtod_pkg::DAY_PRE] * cbtod_pkg::DAY_RECIP;

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			days_s6 <= day_prod[cbtod_pkg::DAY_SHIFT +: 17];
			secs_s6 <= secs_s5;
			cmd_s6  <= cmd_s5;
		end
	end

	// s7: elapsed seconds modulo one day
	logic [SW-1:0] day_secs;
	logic [SW-1:0] step_full;
	logic [16:0]   step_s7;
	logic          cmd_s7;

	assign day_secs  = days_s6 * cbtod_pkg::DAY_SECONDS;
	assign step_full = secs_s6 - day_secs;

	always_ff @(posedge clk) begin
		if (ld[6]) begin
			step_s7 <= step_full[16:0];
			cmd_s7  <= cmd_s6;
		end
	end

	// s8: time of day in seconds since midnight, restart clears it
	logic [16:0] tod_s8;
	logic [17:0] tod_sum;
	logic [16:0] tod_nx;

	always_comb begin
		tod_sum = {1'b0, tod_s8} + {1'b0, step_s7};
		if (tod_sum >= {1'b0, cbtod_pkg::DAY_SECONDS}) begin
			tod_sum = tod_sum - {1'b0, cbtod_pkg::DAY_SECONDS};
		end
		tod_nx = cmd_s7 ? '0 : tod_sum[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tod_s8 <= '0;
		end else if (ld[ST_AC]) begin
			tod_s8 <= tod_nx;
		end
	end

	// s9: hours by reciprocal multiply
	logic [34:0] hour_prod;
	logic [4:0]  hour_s9;
	logic [16:0] tod_s9;

	assign hour_prod = tod_s8 * cbtod_pkg::HOUR_RECIP;

	always_ff @(posedge clk) begin
		if (ld[ST_AC+1]) begin
			hour_s9 <= hour_prod[cbtod_pkg::HOUR_SHIFT +: 5];
			tod_s9  <= tod_s8;
		end
	end

	// s10: seconds within the hour
	logic [16:0] hour_secs;
	logic [16:0] hrem_full;
	logic [11:0] hrem_s10;
	logic [4:0]  hour_s10;

	assign hour_secs = hour_s9 * cbtod_pkg::HOUR_SECS;
	assign hrem_full = tod_s9 - hour_secs;

	always_ff @(posedge clk) begin
		if (ld[ST_AC+2]) begin
			hrem_s10 <= hrem_full[11:0];
			hour_s10 <= hour_s9;
		end
	end

	// s11: minutes by reciprocal multiply
	logic [24:0] min_prod;
	logic [5:0]  min_s11;
	logic [11:0] hrem_s11;
	logic [4:0]  hour_s11;

	assign min_prod = hrem_s10 * cbtod_pkg::MIN_RECIP;

	always_ff @(posedge clk) begin
		if (ld[ST_AC+3]) begin
			min_s11  <= min_prod[cbtod_pkg::MIN_SHIFT +: 6];
			hrem_s11 <= hrem_s10;
			hour_s11 <= hour_s10;
		end
	end

	// s12: seconds within the minute
	logic [11:0] min_secs;
	logic [11:0] sec_full;
	logic [5:0]  sec_s12;
	logic [5:0]  min_s12;
	logic [4:0]  hour_s12;

	assign min_secs = min_s11 * cbtod_pkg::MIN_SECS;
	assign sec_full = hrem_s11 - min_secs;

	always_ff @(posedge clk) begin
		if (ld[ST_AC+4]) begin
			sec_s12  <= sec_full[5:0];
			min_s12  <= min_s11;
			hour_s12 <= hour_s11;
		end
	end

	// s13: split into bcd digits, output register
	logic [2:0] hour_tens_w;

	assign hour_tens_w = cbtod_pkg::tens_of({1'b0, hour_s12});

	always_ff @(posedge clk) begin
		if (ld[ST_AC+5]) begin
			hour_tens   <= hour_tens_w[1:0];
			hour_ones   <= cbtod_pkg::ones_of({1'b0, hour_s12});
			minute_tens <= cbtod_pkg::tens_of(min_s12);
			minute_ones <= cbtod_pkg::ones_of(min_s12);
			second_tens <= cbtod_pkg::tens_of(sec_s12);
			second_ones <= cbtod_pkg::ones_of(sec_s12);
		end
	end

endmodule
